[rtl/aip_pkg.sv]
// Shared types and constants for the ASCII integer parser.
// Holds the transfer payload structs, configuration struct and character codes.
package aip_pkg;

	localparam int MAG_W   = 63;
	localparam int BASE_W  = 6;
	localparam int WIDTH_W = 8;
	localparam int DIGIT_W = 6;

	// Configuration register indexes
	localparam logic [1:0] CFG_NUMBER_BASE    = 2'd0;
	localparam logic [1:0] CFG_WIDTH_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_POSITIVE_LIMIT = 2'd2;
	localparam logic [1:0] CFG_NEGATIVE_LIMIT = 2'd3;

	localparam logic [BASE_W-1:0]  BASE_RESET  = 6'd10;
	localparam logic [BASE_W-1:0]  BASE_MIN    = 6'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX    = 6'd36;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd0;
	localparam logic [MAG_W-1:0]   LIMIT_RESET = 63'd2147483647;

	// Character codes
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] LETTER_BIAS  = 8'd10;

	// Digit value of a character that is neither digit nor letter; above any radix
	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic             number_found;
		logic             is_negative;
		logic [MAG_W-1:0] magnitude;
		logic             saturated;
		logic             char_pushed_back;
	} out_item_t;

	typedef struct packed {
		logic [BASE_W-1:0]  number_base;
		logic [WIDTH_W-1:0] width_limit;
		logic [MAG_W-1:0]   positive_limit;
		logic [MAG_W-1:0]   negative_limit;
	} cfg_t;

	typedef struct packed {
		logic               is_space;
		logic               is_plus;
		logic               is_minus;
		logic [DIGIT_W-1:0] digit;
	} char_class_t;

endpackage

[rtl/aip_char_decode.sv]
// Character classifier for the ASCII integer parser.
// Depends on aip_pkg for character codes and the char_class_t struct.
module aip_char_decode import aip_pkg::*; (
	input  logic [7:0]  char_code,
	output char_class_t cls
);

	logic [7:0] num_off;
	logic [7:0] upper_off;
	logic [7:0] lower_off;

	assign num_off   = char_code - CHAR_ZERO;
	assign upper_off = char_code - CHAR_UPPER_A + LETTER_BIAS;
	assign lower_off = char_code - CHAR_LOWER_A + LETTER_BIAS;

	always_comb begin
		cls.is_space = (char_code == CHAR_SPACE) ||
			((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
		cls.is_plus  = (char_code == CHAR_PLUS);
		cls.is_minus = (char_code == CHAR_MINUS);
		if ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)) begin
			cls.digit = num_off[DIGIT_W-1:0];
		end else if ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z)) begin
			cls.digit = upper_off[DIGIT_W-1:0];
		end else if ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z)) begin
			cls.digit = lower_off[DIGIT_W-1:0];
		end else begin
			cls.digit = DIGIT_NONE;
		end
	end

endmodule

[rtl/aip_parse_core.sv]
// Parse state and combinational next-state logic of the ASCII integer parser.
// Depends on aip_pkg; takes classified characters from aip_char_decode.
module aip_parse_core import aip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	input  char_class_t cls,
	input  cfg_t        cfg,
	output logic        emit,
	output out_item_t   result
);

	localparam int PROD_W = MAG_W + BASE_W;
	localparam int SUM_W  = PROD_W + 1;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_SAT    = 2'd2
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [MAG_W-1:0]   acc_q, acc_d;
	logic               neg_q, neg_d;
	logic [WIDTH_W-1:0] wleft_q, wleft_d;
	logic               seen_q, seen_d;
	logic               ovf_q, ovf_d;

	logic [BASE_W-1:0]  base;
	logic               limited;
	logic [MAG_W-1:0]   limit;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   sum;
	logic               over;
	logic               digit_path;
	logic               pushed;

	always_comb begin
		if (cfg.number_base < BASE_MIN) begin
			base = BASE_MIN;
		end else if (cfg.number_base > BASE_MAX) begin
			base = BASE_MAX;
		end else begin
			base = cfg.number_base;
		end
	end

	assign limited = (cfg.width_limit != '0);
	assign limit   = neg_q ? cfg.negative_limit : cfg.positive_limit;

	// Overflow test as acc*base + digit > limit
	assign prod = PROD_W'(acc_q) * PROD_W'(base);
	assign sum  = SUM_W'(prod) + SUM_W'(cls.digit);
	assign over = (sum > SUM_W'(limit));

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		wleft_d    = wleft_q;
		seen_d     = seen_q;
		ovf_d      = ovf_q;
		emit       = 1'b0;
		pushed     = 1'b0;
		digit_path = 1'b0;

		if (item.end_of_input) begin
			emit = 1'b1;
		end else begin
			case (phase_q)
				PH_DIGITS, PH_SAT: begin
					digit_path = 1'b1;
				end
				default: begin
					if (!cls.is_space) begin
						wleft_d = cfg.width_limit;
						phase_d = PH_DIGITS;
						if (cls.is_plus || cls.is_minus) begin
							neg_d = cls.is_minus;
							if (limited) begin
								wleft_d = cfg.width_limit - 8'd1;
							end
							// A sign that fills the whole width ends the number at once
							if (limited && (wleft_d == '0)) begin
								emit = 1'b1;
							end
						end else begin
							digit_path = 1'b1;
						end
					end
				end
			endcase

			if (digit_path) begin
				if ((limited && (wleft_d == '0)) || (cls.digit >= base)) begin
					emit   = 1'b1;
					pushed = 1'b1;
				end else begin
					if (limited) begin
						wleft_d = wleft_d - 8'd1;
					end
					// In saturation the digit is consumed without changing the value
					if (phase_d == PH_DIGITS) begin
						seen_d = 1'b1;
						if (over) begin
							acc_d   = limit;
							ovf_d   = 1'b1;
							phase_d = PH_SAT;
						end else begin
							acc_d = sum[MAG_W-1:0];
						end
					end
					if (limited && (wleft_d == '0)) begin
						emit = 1'b1;
					end
				end
			end
		end

		result.number_found     = seen_d;
		result.is_negative      = seen_d & neg_d;
		result.magnitude        = seen_d ? acc_d : '0;
		result.saturated        = seen_d & ovf_d;
		result.char_pushed_back = pushed;

		if (emit) begin
			phase_d = PH_SKIP;
			acc_d   = '0;
			neg_d   = 1'b0;
			wleft_d = '0;
			seen_d  = 1'b0;
			ovf_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			wleft_q <= '0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			wleft_q <= wleft_d;
			seen_q  <= seen_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

[rtl/ascii_integer_parser.sv]
// Streaming ASCII-to-integer parser, one character transferred per cycle unless in_stall is
// raised. Input transfers land in an input register; the parse step (character decode, one
// 63x6 multiply by the radix, a 70-bit compare against the sign's limit) runs between that
// register and the result register, so a new character is accepted every cycle unless the
// result register is full and stalled. The transfer that ends the number passes through
// the input register and then the result register, from which the result is offered.
// The loop through the accumulator and that multiply-compare path sets the rate. Leading
// whitespace is skipped, an optional sign uses one unit of width_limit, and digits of radix
// 2..36 (letters of either case for 10 and up) are taken until a non-digit, end of input or
// the width runs out. Beyond the limit the value clamps and further digits valid in the
// radix are consumed. A terminating character is reported with char_pushed_back set and
// must be offered again by the user if it matters. Write configuration only while no
// conversion is under way. Depends on aip_pkg, aip_char_decode and aip_parse_core.
module ascii_integer_parser import aip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [MAG_W-1:0] cfg_data
);

	cfg_t        cfg_q;
	logic        valid_s1;
	in_item_t    data_s1;
	char_class_t cls;
	logic        emit;
	out_item_t   result;
	logic        out_free;
	logic        advance_s1;
	logic        out_valid_q;
	out_item_t   out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.number_base    <= BASE_RESET;
			cfg_q.width_limit    <= WIDTH_RESET;
			cfg_q.positive_limit <= LIMIT_RESET;
			cfg_q.negative_limit <= LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_NUMBER_BASE:    cfg_q.number_base    <= cfg_data[BASE_W-1:0];
				CFG_WIDTH_LIMIT:    cfg_q.width_limit    <= cfg_data[WIDTH_W-1:0];
				CFG_POSITIVE_LIMIT: cfg_q.positive_limit <= cfg_data;
				CFG_NEGATIVE_LIMIT: cfg_q.negative_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held character may move on when the result slot is free or it yields no result
	assign out_free   = !out_valid_q || !out_stall;
	assign advance_s1 = valid_s1 && (out_free || !emit);
	assign in_stall   = valid_s1 && !advance_s1;

	// Input register: hold until the parse step consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	aip_char_decode u_decode (
		.char_code (data_s1.char_code),
		.cls       (cls)
	);

	aip_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance_s1),
		.item   (data_s1),
		.cls    (cls),
		.cfg    (cfg_q),
		.emit   (emit),
		.result (result)
	);

	// Result register: load a finished number, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Input back-pressure only ever comes from a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && emit))
		else $error("input stalled without a blocked result");

	// A finished number always reaches the result register
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && emit) |=> out_valid)
		else $error("emitted result lost");

	// Nothing found reports an empty number
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.number_found) |->
		(!out_data.is_negative && !out_data.saturated && (out_data.magnitude == '0)))
		else $error("not-found result carries a value");

	// A pushed-back character never comes with end of input
	a_pushback_src: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && emit && data_s1.end_of_input) |-> !result.char_pushed_back)
		else $error("end of input reported as pushed back");

endmodule
